### rtl/record_sort_and_rank_macros.svh
// assertion macros for the checker of the sort block
`ifndef RECORD_SORT_AND_RANK_MACROS_SVH
`define RECORD_SORT_AND_RANK_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RSR_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RSR_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/rsr_pkg.sv
package rsr_pkg;

	localparam int ID_W    = 16;
	localparam int SCORE_W = 10;
	localparam int TOTAL_W = 12;
	localparam int RANK_W  = 4;

	// one input record beat
	typedef struct packed {
		logic [ID_W-1:0]    record_id;
		logic [SCORE_W-1:0] score_a;
		logic [SCORE_W-1:0] score_b;
		logic [SCORE_W-1:0] score_c;
		logic               final_item;
	} item_t;

	// one sorted result beat
	typedef struct packed {
		logic [ID_W-1:0]    out_id;
		logic [TOTAL_W-1:0] score_total;
		logic [RANK_W-1:0]  rank;
		logic               end_of_run;
	} result_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic              load;      // insert the current record
		logic              shift;     // pop the head record to the output
		logic              first;     // popped record is the first of the run
		logic              last;      // popped record is the last of the run
		logic [RANK_W-1:0] rank_pos;  // position plus one of the popped record
	} dp_cmd_t;

endpackage

### rtl/rsr_ctrl.sv
module rsr_ctrl
	import rsr_pkg::*;
#(
	parameter int MAX_RECORDS = 8,
	parameter int CNT_W       = $clog2(MAX_RECORDS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             final_item,
	output logic             busy,
	output dp_cmd_t          cmd,
	output logic [CNT_W-1:0] fill
);

	localparam logic [0:0] ST_IDLE  = 1'b0;
	localparam logic [0:0] ST_DRAIN = 1'b1;

	logic [0:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] pos_q;
	logic             accept;
	logic             full;

	// handshake and store status
	assign accept = start && (state_q == ST_IDLE);
	assign full   = (count_q == CNT_W'(MAX_RECORDS));
	assign busy   = (state_q == ST_DRAIN);
	assign fill   = count_q;

	// datapath commands
	always_comb begin
		cmd.load     = accept && !full;
		cmd.shift    = (state_q == ST_DRAIN);
		cmd.first    = (pos_q == '0);
		cmd.last     = (pos_q == (count_q - CNT_W'(1)));
		cmd.rank_pos = RANK_W'(pos_q + CNT_W'(1));
	end

	// load and drain sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pos_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!full) begin
							count_q <= count_q + CNT_W'(1);
						end
						if (final_item) begin
							state_q <= ST_DRAIN;
							pos_q   <= '0;
						end
					end
				end
				ST_DRAIN: begin
					if (cmd.last) begin
						state_q <= ST_IDLE;
						count_q <= '0;
					end else begin
						pos_q <= pos_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/rsr_datapath.sv
module rsr_datapath
	import rsr_pkg::*;
#(
	parameter int MAX_RECORDS = 8,
	parameter int CNT_W       = $clog2(MAX_RECORDS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	input  logic [CNT_W-1:0] fill,
	input  item_t            item,
	output result_t          result,
	output logic             result_strobe
);

	logic [ID_W-1:0]    id_q  [MAX_RECORDS];
	logic [TOTAL_W-1:0] tot_q [MAX_RECORDS];
	logic [MAX_RECORDS-1:0] stay;
	logic [TOTAL_W-1:0] new_total;
	result_t            res_q;
	logic               strobe_q;

	// total of the three scores
	assign new_total = {2'b00, item.score_a} + {2'b00, item.score_b} + {2'b00, item.score_c};

	// sorted row of cells, highest total at cell 0
	for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
		logic               prev_stay;
		logic [ID_W-1:0]    prev_id;
		logic [TOTAL_W-1:0] prev_tot;
		logic [ID_W-1:0]    nxt_id;
		logic [TOTAL_W-1:0] nxt_tot;

		// a filled cell with a total at least the new one keeps its place (stable)
		assign stay[i] = (CNT_W'(i) < fill) && (tot_q[i] >= new_total);

		if (i == 0) begin : g_head
			assign prev_stay = 1'b1;
			assign prev_id   = item.record_id;
			assign prev_tot  = new_total;
		end else begin : g_body
			assign prev_stay = stay[i-1];
			assign prev_id   = id_q[i-1];
			assign prev_tot  = tot_q[i-1];
		end

		if (i == MAX_RECORDS - 1) begin : g_tail
			assign nxt_id  = id_q[i];
			assign nxt_tot = tot_q[i];
		end else begin : g_inner
			assign nxt_id  = id_q[i+1];
			assign nxt_tot = tot_q[i+1];
		end

		// insert opens a slot and moves the rest down, drain moves all up
		always_ff @(posedge clk) begin
			if (cmd.load) begin
				if (!stay[i]) begin
					if (prev_stay) begin
						id_q[i]  <= item.record_id;
						tot_q[i] <= new_total;
					end else begin
						id_q[i]  <= prev_id;
						tot_q[i] <= prev_tot;
					end
				end
			end else if (cmd.shift) begin
				id_q[i]  <= nxt_id;
				tot_q[i] <= nxt_tot;
			end
		end
	end

	// result register with competition rank
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			res_q.out_id      <= id_q[0];
			res_q.score_total <= tot_q[0];
			res_q.end_of_run  <= cmd.last;
			if (cmd.first) begin
				res_q.rank <= RANK_W'(1);
			end else if (tot_q[0] != res_q.score_total) begin
				res_q.rank <= cmd.rank_pos;
			end
		end
	end

	// one strobe per popped record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.shift;
		end
	end

	assign result        = res_q;
	assign result_strobe = strobe_q;

endmodule

### rtl/record_sort_and_rank.sv
// channel  | handshake               | payload
// ---------+-------------------------+---------------------------
// item     | start high, busy low    | item_t   record and final mark
// result   | result_strobe, 1 cycle  | result_t id, total, rank, end
//
// a record is taken while busy is low and inserted into the sorted cell row at once
// unless the store is full; after the beat marked final_item the drain pops one result
// per stored record, so the drain length is set by the count; busy is high during it
// results leave through the single output register, one result a cycle
// reset empties the store; results cannot be stalled by the receiver
module record_sort_and_rank
	import rsr_pkg::*;
#(
	parameter int MAX_RECORDS = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output result_t result,
	output logic    result_strobe
);

	localparam int CNT_W = $clog2(MAX_RECORDS + 1);

	dp_cmd_t          cmd;
	logic [CNT_W-1:0] fill;

	// load and drain sequencer
	rsr_ctrl #(
		.MAX_RECORDS (MAX_RECORDS),
		.CNT_W       (CNT_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.final_item (item.final_item),
		.busy       (busy),
		.cmd        (cmd),
		.fill       (fill)
	);

	// sorted cell row and result register
	rsr_datapath #(
		.MAX_RECORDS (MAX_RECORDS),
		.CNT_W       (CNT_W)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.fill          (fill),
		.item          (item),
		.result        (result),
		.result_strobe (result_strobe)
	);

endmodule

### rtl/rsr_checker.sv
`include "record_sort_and_rank_macros.svh"

module rsr_checker
	import rsr_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input item_t   item,
	input result_t result,
	input logic    result_strobe
);

	// a final record always starts a drain
	`RSR_ASSERT_NXT(a_final_busy, clk, arst_n, start && !busy && item.final_item, busy, "final beat did not start drain")

	// results of one run come back to back
	`RSR_ASSERT_NXT(a_run_solid, clk, arst_n, result_strobe && !result.end_of_run, result_strobe, "gap inside a result run")

	// while results remain the block stays busy, and it is free on the last one
	`RSR_ASSERT_IMP(a_mid_busy, clk, arst_n, result_strobe, busy == !result.end_of_run, "busy out of step with result run")

	// no result follows an idle cycle
	`RSR_ASSERT_NXT(a_idle_quiet, clk, arst_n, !busy, !result_strobe, "result without a drain")

endmodule

bind record_sort_and_rank rsr_checker u_rsr_checker (.*);
